// ===== rtl/signed_int_to_decimal_ascii_core_assert.svh =====
// Assertion macros shared by the converter's RTL files.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SIA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define SIA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/sia_pkg.sv =====
// Shared widths, types and character codes for the integer-to-ASCII converter.
package sia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CHAR_W     = 6;

    // Decimal digits needed for the magnitude 2^(w-1).
    function automatic int dec_digits(input int w);
        longint unsigned v;
        int n;
        v = 64'd1 << (w - 1);
        n = 0;
        while (v != 64'd0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

    localparam int NUM_DIGITS = dec_digits(DATA_WIDTH);
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(DATA_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;

    typedef struct packed {
        logic                neg;
        logic [BCD_BITS-1:0] bcd;
    } conv_word_t;

endpackage

// ===== rtl/sia_bcd_conv.sv =====
// Shift-and-add-3 binary to BCD converter, one magnitude bit per cycle.
`include "signed_int_to_decimal_ascii_core_assert.svh"

module sia_bcd_conv import sia_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] in_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output conv_word_t                   out_word
);

    localparam logic [1:0] CV_IDLE = 2'd0;
    localparam logic [1:0] CV_BUSY = 2'd1;
    localparam logic [1:0] CV_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DATA_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    logic [BCD_BITS-1:0]   bcd_adj;

    // Add 3 to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        case (state_reg)
            CV_IDLE: begin
                if (in_valid) begin
                    neg_next     = in_value[DATA_WIDTH-1];
                    mag_next     = in_value[DATA_WIDTH-1] ?
                                   (~in_value) + DATA_WIDTH'(1) : in_value;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(DATA_WIDTH - 1);
                    state_next   = CV_BUSY;
                end
            end
            CV_BUSY: begin
                bcd_next     = {bcd_adj[BCD_BITS-2:0], mag_reg[DATA_WIDTH-1]};
                mag_next     = {mag_reg[DATA_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == '0) begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE: begin
                if (out_ready) begin
                    state_next = CV_IDLE;
                end
            end
            default: begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bit_cnt_reg <= bit_cnt_next;
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        neg_reg     <= neg_next;
    end

    assign in_ready     = (state_reg == CV_IDLE);
    assign out_valid    = (state_reg == CV_DONE);
    assign out_word.neg = neg_reg;
    assign out_word.bcd = bcd_reg;

    `SIA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready && !out_valid)
    `SIA_ASSERT_NXT(a_done_after_last_bit, (state_reg == CV_BUSY) && (bit_cnt_reg == '0),
                    out_valid)

endmodule

// ===== rtl/sia_char_emit.sv =====
// Character emitter: drops leading zeros, sends sign and digits one word at a time.
`include "signed_int_to_decimal_ascii_core_assert.svh"

module sia_char_emit import sia_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  conv_word_t        in_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_character,
    output logic              m_last
);

    localparam logic [1:0] EM_IDLE = 2'd0;
    localparam logic [1:0] EM_SKIP = 2'd1;
    localparam logic [1:0] EM_SIGN = 2'd2;
    localparam logic [1:0] EM_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [BCD_BITS-1:0]  dig_reg, dig_next;
    logic [DIG_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [3:0]           top_digit;

    assign top_digit = dig_reg[BCD_BITS-1 -: 4];

    always_comb begin
        state_next = state_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        case (state_reg)
            EM_IDLE: begin
                if (in_valid) begin
                    dig_next   = in_word.bcd;
                    neg_next   = in_word.neg;
                    cnt_next   = DIG_CNT_W'(NUM_DIGITS - 1);
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP: begin
                // Drop a leading zero, but always keep the units digit.
                if ((top_digit == 4'd0) && (cnt_reg != '0)) begin
                    dig_next = {dig_reg[BCD_BITS-5:0], 4'd0};
                    cnt_next = cnt_reg - DIG_CNT_W'(1);
                end else begin
                    state_next = neg_reg ? EM_SIGN : EM_EMIT;
                end
            end
            EM_SIGN: begin
                if (m_ready) begin
                    state_next = EM_EMIT;
                end
            end
            EM_EMIT: begin
                if (m_ready) begin
                    if (cnt_reg == '0) begin
                        state_next = EM_IDLE;
                    end else begin
                        dig_next = {dig_reg[BCD_BITS-5:0], 4'd0};
                        cnt_next = cnt_reg - DIG_CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
        end else begin
            state_reg <= state_next;
        end
        dig_reg <= dig_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign in_ready    = (state_reg == EM_IDLE);
    assign m_valid     = (state_reg == EM_SIGN) || (state_reg == EM_EMIT);
    assign m_character = (state_reg == EM_SIGN) ? ASCII_MINUS
                                                : ASCII_ZERO + {2'b00, top_digit};
    assign m_last      = (state_reg == EM_EMIT) && (cnt_reg == '0);

    `SIA_ASSERT_NXT(a_idle_after_last, m_valid && m_ready && m_last, !m_valid)
    `SIA_ASSERT_IMP(a_sign_not_last, m_valid && (state_reg == EM_SIGN), !m_last && neg_reg)

endmodule

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// Top level of the signed integer to decimal ASCII converter.
//
//  channel   ports                         word
//  -------   ---------------------------   ---------------------------------
//  input     s_valid s_ready s_value       one signed DATA_WIDTH-bit integer
//  output    m_valid m_ready m_character   one ASCII character, m_last on the
//            m_last                        final character of the number
//
// An input word is converted by the shift-and-add-3 loop, one magnitude bit per
// cycle, and the converter takes no new word until the emitter has taken the
// last one. The emitter then drops leading zeros and sends the sign and digits
// one character at a time, overlapped with conversion of the next word.
// Reset is synchronous and active low and clears both control state machines.
// A stall on m_ready holds the current character; s_ready stays low meanwhile
// once the converter has a finished word waiting for the emitter.
module signed_int_to_decimal_ascii_core import sia_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [CHAR_W-1:0]            m_character,
    output logic                         m_last
);

    logic       conv_valid;
    logic       conv_ready;
    conv_word_t conv_word;

    sia_bcd_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_word  (conv_word)
    );

    sia_char_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (conv_valid),
        .in_ready    (conv_ready),
        .in_word     (conv_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

// ===== tb/sv/signed_int_to_decimal_ascii_core_tb.sv =====
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core_tb;
    import sia_pkg::*;

    localparam int DIR_ROWS     = 22;
    localparam int RANDOM_WORDS = 300;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic signed [DATA_WIDTH-1:0] s_value     = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic [CHAR_W-1:0]            m_character;
    logic                         m_last;

    char_word_t expected_chars [$];
    int         error_count   = 0;
    int         chars_checked = 0;
    int         cycle_count   = 0;
    int         send_run      = 0;

    // Directed words; an empty text means the expectation comes from the predictor.
    logic signed [DATA_WIDTH-1:0] dir_value [DIR_ROWS] = '{
        32'sd0, 32'sd1, 32'hFFFF_FFFF, 32'sd9, 32'sd10, -32'sd9, -32'sd10,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'sd99, 32'sd100,
        32'sd999999999, 32'sd1000000000, -32'sd1000000000, 32'h5555_5555,
        32'hAAAA_AAAA, 32'sd123456789, -32'sd987654321, 32'h0000_FFFF,
        32'hFFFF_8000, 32'h7FFF_FFFE
    };
    string dir_text [DIR_ROWS] = '{
        "0", "1", "-1", "9", "10", "-9", "-10",
        "2147483647", "-2147483648", "-2147483647", "", "",
        "", "", "", "",
        "", "", "", "",
        "", ""
    };

    signed_int_to_decimal_ascii_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_chars.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Decimal text of a two's complement word, digits built least significant first.
    function automatic string decimal_text(input logic signed [DATA_WIDTH-1:0] v);
        logic [DATA_WIDTH-1:0] mag;
        string digits;
        digits = "";
        mag = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
        do begin
            digits = {$sformatf("%0d", mag % 10), digits};
            mag = mag / 10;
        end while (mag != 0);
        return v[DATA_WIDTH-1] ? {"-", digits} : digits;
    endfunction

    function automatic void queue_text(input string text);
        char_word_t w;
        byte        c;
        for (int i = 0; i < text.len(); i++) begin
            c = text[i];
            w.ch = c[CHAR_W-1:0];
            w.last = (i == text.len() - 1);
            expected_chars.push_back(w);
        end
    endfunction

    function automatic int idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] random_value();
        int unsigned                  pick;
        longint unsigned              p;
        logic signed [DATA_WIDTH-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            v = $urandom;
        end else if (pick < 70) begin
            v = $signed($urandom_range(0, 2000)) - 1000;
        end else if (pick < 85) begin
            // land on and next to powers of ten, where the digit count changes
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = DATA_WIDTH'(p - $urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) v = -v;
        end else if (pick < 92) begin
            case ($urandom_range(0, 3))
                0: v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
                1: v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
                2: v = '1;
                default: v = '0;
            endcase
        end else begin
            v = $urandom >> $urandom_range(0, DATA_WIDTH - 1);
            if ($urandom_range(0, 1) == 1) v = -v;
        end
        return v;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_word(input logic signed [DATA_WIDTH-1:0] v, input string text);
        int gap;
        if (send_run > 0) begin
            send_run--;
            gap = 0;
        end else begin
            gap = idle_length();
            if ($urandom_range(0, 19) == 0) send_run = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        queue_text((text.len() == 0) ? decimal_text(v) : text);
        @(negedge aclk);
    endtask

    // Receiver: ready runs and stalls, plus one long hold that backs up the input.
    initial begin
        int  run_left;
        int  stall_left;
        int  hold_left;
        bit  held_once;
        run_left = 0;
        stall_left = 0;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && chars_checked >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 7);
                stall_left = idle_length();
            end
        end
    end

    always @(posedge aclk) begin
        char_word_t w;
        if (aresetn && m_valid && m_ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word: character %0d last %0b",
                                          m_character, m_last));
            end else begin
                w = expected_chars.pop_front();
                if (m_character !== w.ch)
                    report_mismatch($sformatf("character %0d, expected %0d",
                                              m_character, w.ch));
                if (m_last !== w.last)
                    report_mismatch($sformatf("last %0b, expected %0b (character %0d)",
                                              m_last, w.last, w.ch));
            end
        end
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int i = 0; i < DIR_ROWS; i++)
            offer_word(dir_value[i], dir_text[i]);
        for (int i = 0; i < RANDOM_WORDS; i++)
            offer_word(random_value(), "");
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        // catch any stray words after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
